@@ hdl/saw_pkg.sv @@
`timescale 1ns / 1ps

package saw_pkg;

    localparam int WEIGHT_FRAC_BITS = 17;
    localparam int T_FRAC           = 24;
    localparam int FIELD_W          = 24;
    localparam int ORDER_W          = 3;
    localparam int CFG_IDX_W        = 2;
    localparam int NUM_LANES        = 6;
    localparam int LANE_W           = 3;
    localparam int NUM_STEPS        = 5;
    localparam int STEP_W           = 3;
    localparam int NUM_COEFS        = NUM_STEPS + 1;
    localparam int IDX_W            = 3;
    localparam int NUM_ORDERS       = 6;
    localparam int NUM_COLS         = 3;
    localparam int COL_W            = 2;

    localparam int IN_TDATA_W  = FIELD_W;
    localparam int OUT_TDATA_W = NUM_LANES * FIELD_W;

    // normalization
    localparam int P_W       = 2 * FIELD_W + 1;
    localparam int SAT_SHIFT = 31;
    localparam int RND_SHIFT = 32 - 1 - T_FRAC;
    localparam int T_W       = T_FRAC + 2;
    localparam logic signed [P_W-1:0] P_LIMIT = P_W'(longint'(1) <<< SAT_SHIFT);
    localparam logic signed [P_W-1:0] P_HALF  = P_W'(longint'(1) <<< (RND_SHIFT - 1));

    // horner accumulator
    localparam int COEF_W = 12;
    localparam int ACC_W  = COEF_W + T_FRAC;
    localparam int LO_W   = ACC_W / 2;
    localparam int HI_W   = ACC_W - LO_W;
    localparam int SUM_W  = HI_W + T_W + LO_W;

    // final scaling and division by the odd part of the divisor
    localparam int DSHIFT_W    = 4;
    localparam int ODD_W       = 4;
    localparam int N_W         = ACC_W + WEIGHT_FRAC_BITS + 1;
    localparam int X_W         = 29;
    localparam int RECIP_SHIFT = 32;
    localparam int RECIP_W     = 31;
    localparam int MUL_W       = X_W + RECIP_W;
    localparam logic [ODD_W-1:0] ODD_ONE     = ODD_W'(1);
    localparam logic [ODD_W-1:0] ODD_THREE   = ODD_W'(3);
    localparam logic [ODD_W-1:0] ODD_FIFTEEN = ODD_W'(15);
    localparam logic [RECIP_W-1:0] RECIP_3  = RECIP_W'((longint'(1) << RECIP_SHIFT) / 3);
    localparam logic [RECIP_W-1:0] RECIP_15 = RECIP_W'((longint'(1) << RECIP_SHIFT) / 15);
    localparam logic [FIELD_W-1:0] FIELD_MAX = {FIELD_W{1'b1}};

    localparam logic [ORDER_W-1:0] ORDER_ZERO = ORDER_W'(0);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPLINE_ORDER  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SPACING   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER0_WEIGHT = CFG_IDX_W'(2);

    localparam logic [ORDER_W-1:0] RST_SPLINE_ORDER  = ORDER_W'(3);
    localparam logic [FIELD_W-1:0] RST_INV_SPACING   = FIELD_W'(65536);
    localparam logic [FIELD_W-1:0] RST_ORDER0_WEIGHT = FIELD_W'(131072);

    // stages from input register to output register
    localparam int PIPE_DEPTH = 2 + 2 * NUM_STEPS + 3;
    localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);

    // [order][column][coefficient of t^0..t^5], t = 2x
    localparam int POLY_COEF [NUM_ORDERS][NUM_COLS][NUM_COEFS] = '{
        '{'{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}},
        '{'{1, -1, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}},
        '{'{1, -2, 1, 0, 0, 0}, '{3, 0, -1, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}},
        '{'{1, -3, 3, -1, 0, 0}, '{23, -15, -3, 3, 0, 0}, '{0, 0, 0, 0, 0, 0}},
        '{'{1, -4, 6, -4, 1, 0}, '{19, -22, 6, 2, -1, 0}, '{115, 0, -30, 0, 3, 0}},
        '{'{1, -5, 10, -10, 5, -1}, '{237, -375, 210, -30, -15, 5},
          '{841, -385, -110, 70, 5, -5}}
    };

    // divisor = odd * 2^shift
    localparam int DIV_SHIFT [NUM_ORDERS][NUM_COLS] = '{
        '{0, 0, 0}, '{1, 0, 0}, '{3, 2, 0}, '{4, 4, 0}, '{7, 5, 6}, '{8, 8, 7}
    };
    localparam int DIV_ODD [NUM_ORDERS][NUM_COLS] = '{
        '{1, 1, 1}, '{1, 1, 1}, '{1, 1, 1}, '{3, 3, 1}, '{3, 3, 3}, '{15, 15, 15}
    };

    typedef logic signed [ACC_W-1:0] t_acc;
    typedef logic signed [T_W-1:0]   t_tval;

    typedef struct packed {
        logic [ORDER_W-1:0]    order;
        t_tval                 t;
        t_acc [NUM_LANES-1:0]  acc;
    } t_horner;

    typedef struct packed {
        logic             active;
        logic             neg;
        logic [COL_W-1:0] col;
    } t_lane_map;

    // lanes past the middle use the mirror column at -t
    function automatic t_lane_map lane_map(input logic [ORDER_W-1:0] order,
                                           input logic [LANE_W-1:0] lane);
        t_lane_map m;
        int k;
        int j;
        k = int'(order);
        j = int'(lane);
        m.active = (k >= 1) && (k < NUM_ORDERS) && (j <= k);
        m.neg    = (2 * j > k);
        m.col    = m.neg ? COL_W'(k - j) : COL_W'(j);
        return m;
    endfunction

    function automatic logic signed [COEF_W-1:0] coef(input logic [ORDER_W-1:0] order,
                                                     input logic [LANE_W-1:0] lane,
                                                     input logic [IDX_W-1:0] idx);
        t_lane_map m;
        logic signed [COEF_W-1:0] c;
        m = lane_map(order, lane);
        c = '0;
        if (m.active) begin
            c = COEF_W'(POLY_COEF[order][m.col][idx]);
        end
        return c;
    endfunction

    function automatic logic [DSHIFT_W-1:0] div_shift(input logic [ORDER_W-1:0] order,
                                                      input logic [LANE_W-1:0] lane);
        t_lane_map m;
        logic [DSHIFT_W-1:0] s;
        m = lane_map(order, lane);
        s = '0;
        if (m.active) begin
            s = DSHIFT_W'(DIV_SHIFT[order][m.col]);
        end
        return s;
    endfunction

    function automatic logic [ODD_W-1:0] div_odd(input logic [ORDER_W-1:0] order,
                                                input logic [LANE_W-1:0] lane);
        t_lane_map m;
        logic [ODD_W-1:0] o;
        m = lane_map(order, lane);
        o = ODD_ONE;
        if (m.active) begin
            o = ODD_W'(DIV_ODD[order][m.col]);
        end
        return o;
    endfunction

endpackage

@@ hdl/spline_assignment_weights.sv @@
// B-spline charge-assignment weights for particle-mesh codes.
// Slave stream: one word per particle, tdata = offset from the nearest grid
// point (signed Q8.16). Master stream: one word per input word, tdata holds
// six unsigned Q7.17 weights, weight_a in the lowest 24 bits up to weight_f.
// Unused weights are zero; order 0 returns the order0_weight register in
// weight_a. Configuration: write enable, index (0 spline_order, 1
// inv_spacing, 2 order0_weight) and data; write only while no word is in
// flight.
// Slave acceptance to master tvalid is registered in stages: two stages
// of normalization, two per Horner step for five steps (split multiply, then
// round and add), and three of scaling and division by the odd part of the
// divisor. Throughput is one word per clock unless the master side stalls.
// Every stage holds when the master side stalls; tready of the slave side
// stays high while any stage has room, so no word is lost or repeated.
// Synchronous active-low reset empties the pipeline and loads the register
// defaults: order 3, inverse spacing 1.0, order-0 weight 1.0.
`timescale 1ns / 1ps

module spline_assignment_weights (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [saw_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [saw_pkg::FIELD_W-1:0]         i_cfg_data,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [saw_pkg::IN_TDATA_W-1:0]      i_s_tdata,   // offset
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [saw_pkg::OUT_TDATA_W-1:0]     o_m_tdata    // weight_a .. weight_f
);

    logic [saw_pkg::ORDER_W-1:0]  r_order;
    logic [saw_pkg::FIELD_W-1:0]  r_inv_spacing;
    logic [saw_pkg::FIELD_W-1:0]  r_order0_weight;

    logic                         stg_valid [saw_pkg::NUM_STEPS+1];
    logic                         stg_ready [saw_pkg::NUM_STEPS+1];
    saw_pkg::t_horner             stg_data  [saw_pkg::NUM_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order         <= saw_pkg::RST_SPLINE_ORDER;
            r_inv_spacing   <= saw_pkg::RST_INV_SPACING;
            r_order0_weight <= saw_pkg::RST_ORDER0_WEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                saw_pkg::CFG_SPLINE_ORDER: begin
                    r_order <= i_cfg_data[saw_pkg::ORDER_W-1:0];
                end
                saw_pkg::CFG_INV_SPACING: begin
                    r_inv_spacing <= i_cfg_data;
                end
                saw_pkg::CFG_ORDER0_WEIGHT: begin
                    r_order0_weight <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    saw_norm u_norm (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_order       (r_order),
        .i_inv_spacing (r_inv_spacing),
        .i_valid       (i_s_tvalid),
        .o_ready       (o_s_tready),
        .i_offset      (i_s_tdata),
        .o_valid       (stg_valid[0]),
        .i_ready       (stg_ready[0]),
        .o_data        (stg_data[0])
    );

    for (genvar g = 0; g < saw_pkg::NUM_STEPS; g++) begin : g_step
        saw_horner_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (saw_pkg::STEP_W'(g)),
            .i_valid (stg_valid[g]),
            .o_ready (stg_ready[g]),
            .i_data  (stg_data[g]),
            .o_valid (stg_valid[g+1]),
            .i_ready (stg_ready[g+1]),
            .o_data  (stg_data[g+1])
        );
    end

    saw_scale u_scale (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_order0_weight (r_order0_weight),
        .i_valid         (stg_valid[saw_pkg::NUM_STEPS]),
        .o_ready         (stg_ready[saw_pkg::NUM_STEPS]),
        .i_data          (stg_data[saw_pkg::NUM_STEPS]),
        .o_tvalid        (o_m_tvalid),
        .i_tready        (i_m_tready),
        .o_tdata         (o_m_tdata)
    );

endmodule

@@ hdl/saw_norm.sv @@
`timescale 1ns / 1ps

module saw_norm (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [saw_pkg::ORDER_W-1:0]       i_order,
    input  logic [saw_pkg::FIELD_W-1:0]       i_inv_spacing,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [saw_pkg::FIELD_W-1:0]       i_offset,
    output logic                              o_valid,
    input  logic                              i_ready,
    output saw_pkg::t_horner                  o_data
);

    logic                              r_v1;
    logic                              r_v2;
    logic                              en1;
    logic                              en2;
    logic signed [saw_pkg::P_W-1:0]    r_p;
    logic signed [saw_pkg::P_W-1:0]    n_p;
    logic [saw_pkg::ORDER_W-1:0]       r_order1;
    saw_pkg::t_horner                  r_out;
    saw_pkg::t_horner                  n_out;

    assign en2     = !r_v2 || i_ready;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v2;
    assign o_data  = r_out;

    // offset times inverse spacing, 32 fractional bits
    assign n_p = $signed(i_offset) * $signed({1'b0, i_inv_spacing});

    always_comb begin
        logic signed [saw_pkg::P_W-1:0] sat;
        logic signed [saw_pkg::COEF_W-1:0] c;
        priority if (r_p > saw_pkg::P_LIMIT) begin
            sat = saw_pkg::P_LIMIT;
        end else if (r_p < -saw_pkg::P_LIMIT) begin
            sat = -saw_pkg::P_LIMIT;
        end else begin
            sat = r_p;
        end
        n_out.order = r_order1;
        n_out.t     = saw_pkg::T_W'((sat + saw_pkg::P_HALF) >>> saw_pkg::RND_SHIFT);
        for (int l = 0; l < saw_pkg::NUM_LANES; l++) begin
            c = saw_pkg::coef(r_order1, saw_pkg::LANE_W'(l),
                              saw_pkg::IDX_W'(saw_pkg::NUM_COEFS - 1));
            n_out.acc[l] = {c, {saw_pkg::T_FRAC{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_p      <= n_p;
            r_order1 <= i_order;
        end
        if (en2) begin
            r_out <= n_out;
        end
    end

endmodule

@@ hdl/saw_horner_step.sv @@
`timescale 1ns / 1ps

module saw_horner_step (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [saw_pkg::STEP_W-1:0]   i_step,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  saw_pkg::t_horner             i_data,
    output logic                         o_valid,
    input  logic                         i_ready,
    output saw_pkg::t_horner             o_data
);

    typedef logic signed [saw_pkg::HI_W+saw_pkg::T_W-1:0] t_pp_hi;
    typedef logic signed [saw_pkg::LO_W+saw_pkg::T_W:0]   t_pp_lo;

    typedef struct packed {
        logic [saw_pkg::ORDER_W-1:0]      order;
        saw_pkg::t_tval                   t;
        t_pp_hi [saw_pkg::NUM_LANES-1:0]  hi;
        t_pp_lo [saw_pkg::NUM_LANES-1:0]  lo;
    } t_partial;

    logic                           r_v1;
    logic                           r_v2;
    logic                           en1;
    logic                           en2;
    t_partial                       r_part;
    t_partial                       n_part;
    saw_pkg::t_horner               r_out;
    saw_pkg::t_horner               n_out;
    logic [saw_pkg::IDX_W-1:0]      coef_idx;

    assign en2     = !r_v2 || i_ready;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v2;
    assign o_data  = r_out;

    assign coef_idx = saw_pkg::IDX_W'(saw_pkg::NUM_STEPS - 1) - saw_pkg::IDX_W'(i_step);

    // partial products of acc * t, acc split in halves
    always_comb begin
        logic signed [saw_pkg::T_W-1:0]  tl;
        logic signed [saw_pkg::HI_W-1:0] ah;
        logic [saw_pkg::LO_W-1:0]        al;
        saw_pkg::t_lane_map              m;
        n_part.order = i_data.order;
        n_part.t     = i_data.t;
        for (int l = 0; l < saw_pkg::NUM_LANES; l++) begin
            m  = saw_pkg::lane_map(i_data.order, saw_pkg::LANE_W'(l));
            tl = m.neg ? -i_data.t : i_data.t;
            ah = $signed(i_data.acc[l][saw_pkg::ACC_W-1:saw_pkg::LO_W]);
            al = i_data.acc[l][saw_pkg::LO_W-1:0];
            n_part.hi[l] = ah * tl;
            n_part.lo[l] = $signed({1'b0, al}) * tl;
        end
    end

    // recombine, round, add next coefficient
    always_comb begin
        logic signed [saw_pkg::SUM_W-1:0]  sum;
        logic signed [saw_pkg::COEF_W-1:0] c;
        n_out.order = r_part.order;
        n_out.t     = r_part.t;
        for (int l = 0; l < saw_pkg::NUM_LANES; l++) begin
            sum = (saw_pkg::SUM_W'($signed(r_part.hi[l])) <<< saw_pkg::LO_W)
                + saw_pkg::SUM_W'($signed(r_part.lo[l]))
                + (saw_pkg::SUM_W'(1) <<< (saw_pkg::T_FRAC - 1));
            c = saw_pkg::coef(r_part.order, saw_pkg::LANE_W'(l), coef_idx);
            n_out.acc[l] = saw_pkg::ACC_W'(sum >>> saw_pkg::T_FRAC)
                         + {c, {saw_pkg::T_FRAC{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_part <= n_part;
        end
        if (en2) begin
            r_out <= n_out;
        end
    end

endmodule

@@ hdl/saw_scale.sv @@
`timescale 1ns / 1ps

module saw_scale (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [saw_pkg::FIELD_W-1:0]         i_order0_weight,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  saw_pkg::t_horner                    i_data,
    output logic                                o_tvalid,
    input  logic                                i_tready,
    output logic [saw_pkg::OUT_TDATA_W-1:0]     o_tdata
);

    logic                                r_v1;
    logic                                r_v2;
    logic                                r_v3;
    logic                                en1;
    logic                                en2;
    logic                                en3;

    logic [saw_pkg::ORDER_W-1:0]         r_order1;
    logic [saw_pkg::NUM_LANES-1:0]       r_pos1;
    logic [saw_pkg::X_W-1:0]             r_x1   [saw_pkg::NUM_LANES];
    logic [saw_pkg::ODD_W-1:0]           r_odd1 [saw_pkg::NUM_LANES];
    logic [saw_pkg::NUM_LANES-1:0]       n_pos1;
    logic [saw_pkg::X_W-1:0]             n_x1   [saw_pkg::NUM_LANES];
    logic [saw_pkg::ODD_W-1:0]           n_odd1 [saw_pkg::NUM_LANES];

    logic [saw_pkg::ORDER_W-1:0]         r_order2;
    logic [saw_pkg::NUM_LANES-1:0]       r_pos2;
    logic [saw_pkg::X_W-1:0]             r_x2   [saw_pkg::NUM_LANES];
    logic [saw_pkg::ODD_W-1:0]           r_odd2 [saw_pkg::NUM_LANES];
    logic [saw_pkg::MUL_W-1:0]           r_prod [saw_pkg::NUM_LANES];
    logic [saw_pkg::MUL_W-1:0]           n_prod [saw_pkg::NUM_LANES];

    logic [saw_pkg::OUT_TDATA_W-1:0]     r_tdata;
    logic [saw_pkg::OUT_TDATA_W-1:0]     n_tdata;

    assign en3      = !r_v3 || i_tready;
    assign en2      = !r_v2 || en3;
    assign en1      = !r_v1 || en2;
    assign o_ready  = en1;
    assign o_tvalid = r_v3;
    assign o_tdata  = r_tdata;

    // scale by 2^frac, round, divide by the power-of-two part
    always_comb begin
        saw_pkg::t_acc                acc;
        saw_pkg::t_lane_map           m;
        logic [saw_pkg::DSHIFT_W-1:0] sh;
        logic [saw_pkg::ODD_W-1:0]    odd;
        logic [saw_pkg::N_W-1:0]      nsum;
        for (int l = 0; l < saw_pkg::NUM_LANES; l++) begin
            acc  = i_data.acc[l];
            m    = saw_pkg::lane_map(i_data.order, saw_pkg::LANE_W'(l));
            sh   = saw_pkg::div_shift(i_data.order, saw_pkg::LANE_W'(l));
            odd  = saw_pkg::div_odd(i_data.order, saw_pkg::LANE_W'(l));
            nsum = (saw_pkg::N_W'(acc) << saw_pkg::WEIGHT_FRAC_BITS)
                 + (saw_pkg::N_W'(odd) << (saw_pkg::T_FRAC - 1 + int'(sh)));
            n_pos1[l] = m.active && !acc[saw_pkg::ACC_W-1] && (acc != '0);
            n_x1[l]   = saw_pkg::X_W'(nsum >> (saw_pkg::T_FRAC + int'(sh)));
            n_odd1[l] = odd;
        end
    end

    // reciprocal multiply for the odd part
    always_comb begin
        logic [saw_pkg::RECIP_W-1:0] recip;
        for (int l = 0; l < saw_pkg::NUM_LANES; l++) begin
            recip     = (r_odd1[l] == saw_pkg::ODD_THREE) ? saw_pkg::RECIP_3
                                                          : saw_pkg::RECIP_15;
            n_prod[l] = saw_pkg::MUL_W'(r_x1[l]) * saw_pkg::MUL_W'(recip);
        end
    end

    // quotient correction, clamp, pack
    always_comb begin
        logic [saw_pkg::X_W-1:0]     q0;
        logic [saw_pkg::X_W-1:0]     q;
        logic [saw_pkg::X_W-1:0]     rem;
        logic [saw_pkg::FIELD_W-1:0] w;
        n_tdata = '0;
        for (int l = 0; l < saw_pkg::NUM_LANES; l++) begin
            q0  = saw_pkg::X_W'(r_prod[l] >> saw_pkg::RECIP_SHIFT);
            rem = r_x2[l] - saw_pkg::X_W'(q0 * r_odd2[l]);
            priority if (r_odd2[l] == saw_pkg::ODD_ONE) begin
                q = r_x2[l];
            end else if (rem >= saw_pkg::X_W'(r_odd2[l])) begin
                q = q0 + 1'b1;
            end else begin
                q = q0;
            end
            if (q > saw_pkg::X_W'(saw_pkg::FIELD_MAX)) begin
                w = saw_pkg::FIELD_MAX;
            end else begin
                w = q[saw_pkg::FIELD_W-1:0];
            end
            n_tdata[l*saw_pkg::FIELD_W +: saw_pkg::FIELD_W] = r_pos2[l] ? w : '0;
        end
        if (r_order2 == saw_pkg::ORDER_ZERO) begin
            n_tdata[saw_pkg::FIELD_W-1:0] = i_order0_weight;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_order1 <= i_data.order;
            r_pos1   <= n_pos1;
            r_x1     <= n_x1;
            r_odd1   <= n_odd1;
        end
        if (en2) begin
            r_order2 <= r_order1;
            r_pos2   <= r_pos1;
            r_x2     <= r_x1;
            r_odd2   <= r_odd1;
            r_prod   <= n_prod;
        end
        if (en3) begin
            r_tdata <= n_tdata;
        end
    end

endmodule

@@ hdl/saw_checker.sv @@
`timescale 1ns / 1ps

module saw_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    input  logic                                o_s_tready,
    input  logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    input  logic [saw_pkg::OUT_TDATA_W-1:0]     o_m_tdata
);

    logic                        s_acc;
    logic                        m_acc;
    logic [saw_pkg::CNT_W-1:0]   r_cnt;
    logic [saw_pkg::CNT_W-1:0]   n_cnt;

    assign s_acc = i_s_tvalid && o_s_tready;
    assign m_acc = o_m_tvalid && i_m_tready;
    assign n_cnt = r_cnt + saw_pkg::CNT_W'(s_acc) - saw_pkg::CNT_W'(m_acc);

    // words in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output word changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_tvalid || i_m_tready) |-> o_s_tready)
        else $error("input stalled with a free output stage");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> r_cnt != '0)
        else $error("output word without an accepted input");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= saw_pkg::CNT_W'(saw_pkg::PIPE_DEPTH))
        else $error("more words in flight than pipeline stages");

endmodule

bind spline_assignment_weights saw_checker u_saw_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

@@ sim/spline_assignment_weights_tb.sv @@
`timescale 1ns / 1ps

module spline_assignment_weights_tb;

    localparam int DRAIN_CYCLES = 20;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int RANDOM_PHASES = 15;
    localparam logic [saw_pkg::FIELD_W-1:0] ALL_ONES = {saw_pkg::FIELD_W{1'b1}};

    // [order][column][coefficient of t^0..t^5], t = 2x
    localparam int SPLINE_POLY [6][3][6] = '{
        '{'{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}},
        '{'{1, -1, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}},
        '{'{1, -2, 1, 0, 0, 0}, '{3, 0, -1, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}},
        '{'{1, -3, 3, -1, 0, 0}, '{23, -15, -3, 3, 0, 0}, '{0, 0, 0, 0, 0, 0}},
        '{'{1, -4, 6, -4, 1, 0}, '{19, -22, 6, 2, -1, 0}, '{115, 0, -30, 0, 3, 0}},
        '{'{1, -5, 10, -10, 5, -1}, '{237, -375, 210, -30, -15, 5},
          '{841, -385, -110, 70, 5, -5}}
    };
    localparam int SPLINE_DIV [6][3] = '{
        '{1, 1, 1}, '{2, 1, 1}, '{8, 4, 1}, '{48, 48, 1}, '{384, 96, 192},
        '{3840, 3840, 1920}
    };

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 i_cfg_we = 1'b0;
    logic [saw_pkg::CFG_IDX_W-1:0]        i_cfg_idx = '0;
    logic [saw_pkg::FIELD_W-1:0]          i_cfg_data = '0;
    logic                                 i_s_tvalid = 1'b0;
    logic                                 o_s_tready;
    logic [saw_pkg::IN_TDATA_W-1:0]       i_s_tdata = '0;   // offset
    logic                                 o_m_tvalid;
    logic                                 i_m_tready = 1'b1;
    logic [saw_pkg::OUT_TDATA_W-1:0]      o_m_tdata;        // weight_a .. weight_f

    spline_assignment_weights dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // register copies for the predictor
    logic [saw_pkg::ORDER_W-1:0] cur_order = saw_pkg::RST_SPLINE_ORDER;
    logic [saw_pkg::FIELD_W-1:0] cur_inv   = saw_pkg::RST_INV_SPACING;
    logic [saw_pkg::FIELD_W-1:0] cur_w0    = saw_pkg::RST_ORDER0_WEIGHT;

    logic [saw_pkg::OUT_TDATA_W-1:0] weights_due [$];
    int mismatch_count = 0;
    bit no_idling = 1'b0;

    string lane_name [saw_pkg::NUM_LANES] = '{"weight_a", "weight_b", "weight_c",
                                              "weight_d", "weight_e", "weight_f"};

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [saw_pkg::FIELD_W-1:0] spline_column(input int k, input int col,
                                                                  input longint tv);
        longint acc;
        longint den;
        longint w;
        int i;
        acc = longint'(SPLINE_POLY[k][col][k]) <<< saw_pkg::T_FRAC;
        for (i = k - 1; i >= 0; i--) begin
            acc = ((acc * tv + (longint'(1) <<< (saw_pkg::T_FRAC - 1))) >>> saw_pkg::T_FRAC)
                  + (longint'(SPLINE_POLY[k][col][i]) <<< saw_pkg::T_FRAC);
        end
        if (acc <= 0) begin
            return '0;
        end
        den = longint'(SPLINE_DIV[k][col]) <<< saw_pkg::T_FRAC;
        w = ((acc <<< saw_pkg::WEIGHT_FRAC_BITS) + (den >>> 1)) / den;
        if (w > longint'(ALL_ONES)) begin
            return ALL_ONES;
        end
        return w[saw_pkg::FIELD_W-1:0];
    endfunction

    function automatic logic [saw_pkg::OUT_TDATA_W-1:0] predict_weights(
            input logic [saw_pkg::FIELD_W-1:0] off_bits);
        logic [saw_pkg::OUT_TDATA_W-1:0] res;
        longint off;
        longint p;
        longint t;
        longint lim;
        int k;
        int j;
        res = '0;
        k = int'(cur_order);
        off = longint'($signed(off_bits));
        if (k == 0) begin
            res[saw_pkg::FIELD_W-1:0] = cur_w0;
            return res;
        end
        if (k > 5) begin
            return res;
        end
        lim = longint'(1) <<< 31;
        p = off * longint'(cur_inv);
        if (p > lim) p = lim;
        if (p < -lim) p = -lim;
        t = (p + (longint'(1) <<< 6)) >>> 7;
        lim = longint'(1) <<< saw_pkg::T_FRAC;
        if (t > lim) t = lim;
        if (t < -lim) t = -lim;
        for (j = 0; j <= k; j++) begin
            if (2 * j <= k) begin
                res[saw_pkg::FIELD_W*j +: saw_pkg::FIELD_W] = spline_column(k, j, t);
            end else begin
                res[saw_pkg::FIELD_W*j +: saw_pkg::FIELD_W] = spline_column(k, k - j, -t);
            end
        end
        return res;
    endfunction

    // mostly offsets that land near [-0.5, 0.5] after scaling, some anywhere
    function automatic logic [saw_pkg::FIELD_W-1:0] pick_offset();
        longint lim;
        longint off;
        if (cur_inv == '0) begin
            lim = 8388607;
        end else begin
            lim = (longint'(1) <<< 31) / longint'(cur_inv);
            lim = lim + lim / 4 + 2;
            if (lim > 8388607) lim = 8388607;
        end
        if ($urandom_range(0, 9) < 7) begin
            off = longint'($urandom_range(0, int'(2 * lim))) - lim;
        end else begin
            off = longint'($urandom());
        end
        return off[saw_pkg::FIELD_W-1:0];
    endfunction

    task automatic send_offset(input logic [saw_pkg::FIELD_W-1:0] off);
        int gap;
        gap = no_idling ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= off;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        weights_due.push_back(predict_weights(off));
    endtask

    task automatic drain_pipeline();
        i_s_tvalid <= 1'b0;
        while (weights_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic [saw_pkg::ORDER_W-1:0] order,
                             input logic [saw_pkg::FIELD_W-1:0] inv,
                             input logic [saw_pkg::FIELD_W-1:0] w0);
        drain_pipeline();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= saw_pkg::CFG_SPLINE_ORDER;
        i_cfg_data <= saw_pkg::FIELD_W'(order);
        @(posedge i_clk);
        cur_order = order;
        i_cfg_idx  <= saw_pkg::CFG_INV_SPACING;
        i_cfg_data <= inv;
        @(posedge i_clk);
        cur_inv = inv;
        i_cfg_idx  <= saw_pkg::CFG_ORDER0_WEIGHT;
        i_cfg_data <= w0;
        @(posedge i_clk);
        cur_w0 = w0;
        i_cfg_we <= 1'b0;
    endtask

    // default registers: order 3, unit spacing
    task automatic test_reset_defaults();
        send_offset(24'h000000);
        send_offset(24'h008000);
        send_offset(24'hFF8000);
        send_offset(24'h7FFFFF);
        send_offset(24'h800000);
        send_offset(24'h000001);
        send_offset(24'hFFFFFF);
    endtask

    // each order at center and at both saturation ends
    task automatic test_each_order();
        for (int k = 0; k < saw_pkg::NUM_ORDERS; k++) begin
            configure(saw_pkg::ORDER_W'(k), saw_pkg::RST_INV_SPACING, ALL_ONES);
            send_offset(24'h000000);
            send_offset(24'h7FFFFF);
            send_offset(24'h800000);
        end
    endtask

    task automatic test_random_phases();
        logic [saw_pkg::FIELD_W-1:0] inv;
        logic [saw_pkg::FIELD_W-1:0] w0;
        logic [saw_pkg::ORDER_W-1:0] order;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            order = (ph < 12) ? saw_pkg::ORDER_W'(ph % saw_pkg::NUM_ORDERS)
                              : saw_pkg::ORDER_W'($urandom_range(0, 5));
            unique case (ph)
                3, 10: begin
                    inv = '0;
                end
                5, 7: begin
                    inv = ALL_ONES;
                end
                default: begin
                    if ($urandom_range(0, 1) == 0) begin
                        inv = saw_pkg::FIELD_W'($urandom_range(1, 24'hFFFFFF));
                    end else begin
                        inv = saw_pkg::FIELD_W'($urandom_range(1 << 14, 1 << 18));
                    end
                end
            endcase
            unique case (ph)
                0: w0 = '0;
                6: w0 = ALL_ONES;
                default: w0 = saw_pkg::FIELD_W'($urandom());
            endcase
            configure(order, inv, w0);
            no_idling = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_offset(pick_offset());
            end
        end
        no_idling = 1'b0;
    endtask

    // result checker and sink-side stalls
    logic [saw_pkg::OUT_TDATA_W-1:0] exp_word;
    int sink_hold = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (weights_due.size() == 0) begin
                    $error("output word with no weights expected, tdata %h", o_m_tdata);
                    mismatch_count++;
                end else begin
                    exp_word = weights_due.pop_front();
                    for (int j = 0; j < saw_pkg::NUM_LANES; j++) begin
                        if (o_m_tdata[saw_pkg::FIELD_W*j +: saw_pkg::FIELD_W]
                            !== exp_word[saw_pkg::FIELD_W*j +: saw_pkg::FIELD_W]) begin
                            $error("%s expected %0d got %0d", lane_name[j],
                                   exp_word[saw_pkg::FIELD_W*j +: saw_pkg::FIELD_W],
                                   o_m_tdata[saw_pkg::FIELD_W*j +: saw_pkg::FIELD_W]);
                            mismatch_count++;
                        end
                    end
                end
                sink_hold = no_idling ? 0 : $urandom_range(0, 8);
            end else if (sink_hold > 0) begin
                sink_hold--;
            end
            i_m_tready <= (sink_hold == 0);
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_each_order();
        test_random_phases();
        drain_pipeline();
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
